@@ rtl/rational_arith_reduce_assert.svh @@
// Assertion macros for the rational reduction block.
`ifndef RATIONAL_ARITH_REDUCE_ASSERT_SVH
`define RATIONAL_ARITH_REDUCE_ASSERT_SVH
`ifndef ASSERT_OFF
`define RAR_ASSERT_IMP(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("assertion failed");
`define RAR_ASSERT_NXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("assertion failed");
`else
`define RAR_ASSERT_IMP(label, clk, rst_n, ante, cons)
`define RAR_ASSERT_NXT(label, clk, rst_n, ante, cons)
`endif
`endif

@@ rtl/rar_pkg.sv @@
package rar_pkg;
	localparam logic [2:0] CMD_ADD = 3'd0;
	localparam logic [2:0] CMD_SUB = 3'd1;
	localparam logic [2:0] CMD_MUL = 3'd2;
	localparam logic [2:0] CMD_DIV = 3'd3;
	localparam logic [2:0] CMD_GCD = 3'd4;

	typedef struct packed {
		logic [2:0] cmd;
		logic signed [31:0] a_num;
		logic signed [31:0] a_den;
		logic signed [31:0] b_num;
		logic signed [31:0] b_den;
	} in_t;

	typedef struct packed {
		logic signed [63:0] res_num;
		logic signed [63:0] res_den;
	} out_t;

	// Classified item handed from the front to the back.
	typedef struct packed {
		logic        reduce;
		logic        zero;
		logic [63:0] n;
		logic [63:0] d;
		logic [63:0] den;
	} job_t;
endpackage

@@ rtl/rar_divider.sv @@
// Restoring signed divider, truncated quotient and remainder, one bit per cycle.
module rar_divider (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        go,
	input  logic [63:0] dividend,
	input  logic [63:0] divisor,
	output logic        done,
	output logic [63:0] quot,
	output logic [63:0] rem
);
	logic [63:0] a_q, b_q, q_q;
	logic [64:0] r_q;
	logic [6:0]  cnt_q;
	logic        run_q, qneg_q, rneg_q, zero_q;
	logic [64:0] trial;
	logic [64:0] rsh;

	assign rsh   = {r_q[63:0], a_q[63]};
	assign trial = rsh - {1'b0, b_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			run_q <= 1'b0;
			done  <= 1'b0;
			cnt_q <= '0;
		end else begin
			done <= !go && run_q && (cnt_q == 7'd1);
			if (go) begin
				run_q  <= 1'b1;
				cnt_q  <= 7'd64;
				a_q    <= dividend[63] ? (64'd0 - dividend) : dividend;
				b_q    <= divisor[63] ? (64'd0 - divisor) : divisor;
				qneg_q <= dividend[63] ^ divisor[63];
				rneg_q <= dividend[63];
				zero_q <= (divisor == 64'd0);
				r_q    <= '0;
				q_q    <= '0;
			end else if (run_q) begin
				a_q <= {a_q[62:0], 1'b0};
				if (!trial[64]) begin
					r_q <= trial;
					q_q <= {q_q[62:0], 1'b1};
				end else begin
					r_q <= rsh;
					q_q <= {q_q[62:0], 1'b0};
				end
				cnt_q <= cnt_q - 7'd1;
				if (cnt_q == 7'd1) begin
					run_q <= 1'b0;
				end
			end
		end
	end

	always_comb begin
		if (zero_q) begin
			quot = '0;
			rem  = '0;
		end else begin
			quot = qneg_q ? (64'd0 - q_q) : q_q;
			rem  = rneg_q ? (64'd0 - r_q[63:0]) : r_q[63:0];
		end
	end
endmodule

@@ rtl/rar_front.sv @@
// Sign-extends operands and forms the cross products one after another.
module rar_front #(
	parameter int OPERAND_WIDTH = 32
) (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           take,
	input  rar_pkg::in_t   item,
	output logic           busy,
	output logic           job_valid,
	input  logic           job_ready,
	output rar_pkg::job_t  job
);
	logic [2:0]         cmd_q;
	logic signed [31:0] an_q, ad_q, bn_q, bd_q;
	logic [63:0]        p0_q, p1_q, p2_q;
	logic [1:0]         ph_q;
	logic               act_q, vld_q;

	function automatic logic signed [31:0] sx(input logic [31:0] v);
		logic signed [OPERAND_WIDTH-1:0] t;
		t = v[OPERAND_WIDTH-1:0];
		return 32'(t);
	endfunction

	assign busy      = act_q || vld_q;
	assign job_valid = vld_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			act_q <= 1'b0;
			vld_q <= 1'b0;
			ph_q  <= '0;
		end else begin
			if (vld_q && job_ready) vld_q <= 1'b0;
			if (take) begin
				act_q <= 1'b1;
				ph_q  <= 2'd0;
				cmd_q <= item.cmd;
				an_q  <= sx(item.a_num);
				ad_q  <= sx(item.a_den);
				bn_q  <= sx(item.b_num);
				bd_q  <= sx(item.b_den);
			end else if (act_q) begin
				ph_q <= ph_q + 2'd1;
				// One 32x32 signed product per cycle; the full 64-bit product is kept.
				unique case (ph_q)
					2'd0: p0_q <= an_q * (cmd_q == rar_pkg::CMD_MUL ? bn_q : bd_q);
					2'd1: p1_q <= (cmd_q == rar_pkg::CMD_MUL ? bd_q : bn_q) * ad_q;
					2'd2: p2_q <= ad_q * bd_q;
					default: begin
						act_q <= 1'b0;
						vld_q <= 1'b1;
					end
				endcase
			end
		end
	end

	always_comb begin
		job.reduce = 1'b1;
		job.zero   = 1'b0;
		job.n      = '0;
		job.d      = p2_q;
		job.den    = p2_q;
		case (cmd_q)
			rar_pkg::CMD_ADD: job.n = p0_q + p1_q;
			rar_pkg::CMD_SUB: job.n = p0_q - p1_q;
			rar_pkg::CMD_MUL: job.d = p1_q;
			rar_pkg::CMD_DIV: begin
				job.n = p0_q;
				job.d = p1_q;
			end
			rar_pkg::CMD_GCD: begin
				job.reduce = 1'b0;
				job.n      = p0_q;
				job.d      = p1_q;
			end
			default: job.zero = 1'b1;
		endcase
		if (cmd_q == rar_pkg::CMD_MUL) job.n = p0_q;
	end
endmodule

@@ rtl/rar_back.sv @@
// Runs Euclid on the shared divider, then, for a reducing job, divides both terms by the gcd.
module rar_back (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          job_valid,
	output logic          job_ready,
	input  rar_pkg::job_t job,
	output logic          strobe,
	output rar_pkg::out_t result
);
	typedef enum logic [4:0] {
		S_IDLE = 5'b00001, S_GCD = 5'b00010, S_QN = 5'b00100,
		S_QD = 5'b01000, S_OUT = 5'b10000
	} st_t;
	st_t st_q;
	logic [63:0] x_q, y_q, n_q, d_q, g_q, qn_q, den_q;
	logic        red_q, go, done, wait_q;
	logic [63:0] dv_a, dv_b, quot, rem;

	rar_divider u_div (.clk, .arst_n, .go, .dividend(dv_a), .divisor(dv_b),
		.done, .quot, .rem);

	assign job_ready = (st_q == S_IDLE);
	assign dv_a = (st_q == S_GCD) ? x_q : (st_q == S_QN ? n_q : d_q);
	assign dv_b = (st_q == S_GCD) ? y_q : g_q;

	always_comb begin
		go = 1'b0;
		if (!wait_q) begin
			if (st_q == S_GCD) go = (y_q != 64'd0) && (y_q != '1);
			if (st_q == S_QN || st_q == S_QD) go = (g_q != '1);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q   <= S_IDLE;
			strobe <= 1'b0;
			wait_q <= 1'b0;
		end else begin
			strobe <= (st_q == S_OUT);
			if (go) wait_q <= 1'b1;
			unique case (st_q)
				S_IDLE: if (job_valid) begin
					n_q <= job.n;
					d_q <= job.d;
					den_q <= job.den;
					// Both terms zero: the gcd is taken as one.
					x_q <= (job.n == 64'd0 && job.d == 64'd0) ? 64'd1 : job.n;
					y_q <= job.d;
					red_q <= job.reduce;
					if (job.zero) begin
						result.res_num <= '0;
						result.res_den <= '0;
						st_q <= S_OUT;
					end else st_q <= S_GCD;
				end
				S_GCD: if (y_q == 64'd0) begin
					g_q <= x_q;
					if (red_q) st_q <= S_QN;
					else begin
						result.res_num <= x_q;
						result.res_den <= den_q;
						st_q <= S_OUT;
					end
				end else if (y_q == '1) begin
					x_q <= y_q;
					y_q <= '0;
				end else if (done) begin
					wait_q <= 1'b0;
					x_q <= y_q;
					y_q <= rem;
				end
				S_QN: if (g_q == '1) begin
					qn_q <= 64'd0 - n_q;
					st_q <= S_QD;
				end else if (done) begin
					wait_q <= 1'b0;
					qn_q <= quot;
					st_q <= S_QD;
				end
				S_QD: if (g_q == '1) begin
					result.res_num <= qn_q;
					result.res_den <= 64'd0 - d_q;
					st_q <= S_OUT;
				end else if (done) begin
					wait_q <= 1'b0;
					result.res_num <= qn_q;
					result.res_den <= quot;
					st_q <= S_OUT;
				end
				S_OUT: st_q <= S_IDLE;
				default: st_q <= S_IDLE;
			endcase
		end
	end
endmodule

@@ rtl/rational_arith_reduce.sv @@
// Rational arithmetic with gcd reduction.
// Raise start with an operand struct on item while busy is low; that edge
// makes the transfer. busy stays high until the result has been strobed.
// The front forms the cross products (one 32x32 multiply per cycle),
// hands the job to the back through a one-entry hand-off register, and
// the back runs Euclid on a shared 64-step restoring divider, then, for
// a reducing job, divides numerator and denominator by the gcd on the
// same unit. A new item is taken only after the last result is strobed.
// The result appears on result for exactly one cycle with strobe high; the
// receiver cannot stall and must take it then.
// Reset clears all control state; nothing is in flight afterwards.
`include "rational_arith_reduce_assert.svh"
module rational_arith_reduce #(
	parameter int OPERAND_WIDTH = 32
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          start,
	input  rar_pkg::in_t  item,
	output logic          busy,
	output logic          strobe,
	output rar_pkg::out_t result
);
	logic          fbusy, jv, jr, pend_q;
	rar_pkg::job_t job;

	rar_front #(.OPERAND_WIDTH(OPERAND_WIDTH)) u_front (.clk, .arst_n,
		.take(start && !busy), .item, .busy(fbusy), .job_valid(jv),
		.job_ready(jr), .job);

	rar_back u_back (.clk, .arst_n, .job_valid(jv), .job_ready(jr), .job,
		.strobe, .result);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) pend_q <= 1'b0;
		else if (start && !busy) pend_q <= 1'b1;
		else if (strobe) pend_q <= 1'b0;
	end
	assign busy = fbusy || pend_q;

	`RAR_ASSERT_NXT(a_busy_after_start, clk, arst_n, start && !busy, busy)
	`RAR_ASSERT_IMP(a_no_strobe_idle, clk, arst_n, strobe, pend_q)
endmodule

@@ tb/rational_arith_reduce_check.sv @@
module rational_arith_reduce_check (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          start,
	input  logic          busy,
	input  rar_pkg::in_t  item,
	input  logic          strobe,
	input  rar_pkg::out_t result,
	output int            fail_count,
	output int            pending,
	output int            checked
);
	timeunit 1ns;
	timeprecision 1ps;

	rar_pkg::out_t reduced_q[$];

	// Truncated remainder; a divisor of zero or minus one yields zero.
	function automatic longint trunc_rem(longint x, longint y);
		if (y == 0 || y == -1) begin
			return 0;
		end
		return x % y;
	endfunction

	function automatic longint trunc_quot(longint x, longint y);
		if (y == 0) begin
			return 0;
		end
		if (y == -1) begin
			return -x;
		end
		return x / y;
	endfunction

	function automatic longint euclid_gcd(longint x, longint y);
		longint t;
		if (x == 0 && y == 0) begin
			return 1;
		end
		while (y != 0) begin
			t = y;
			y = trunc_rem(x, y);
			x = t;
		end
		return x;
	endfunction

	function automatic rar_pkg::out_t reduce_rational(rar_pkg::in_t op);
		longint an, ad, bn, bd, n, d, g;
		rar_pkg::out_t r;
		an = op.a_num;
		ad = op.a_den;
		bn = op.b_num;
		bd = op.b_den;
		n = 0;
		d = 0;
		case (op.cmd)
			rar_pkg::CMD_ADD: begin
				n = an * bd + bn * ad;
				d = ad * bd;
			end
			rar_pkg::CMD_SUB: begin
				n = an * bd - bn * ad;
				d = ad * bd;
			end
			rar_pkg::CMD_MUL: begin
				n = an * bn;
				d = ad * bd;
			end
			rar_pkg::CMD_DIV: begin
				n = an * bd;
				d = ad * bn;
			end
			rar_pkg::CMD_GCD: begin
				r.res_num = euclid_gcd(an * bd, ad * bn);
				r.res_den = ad * bd;
				return r;
			end
			default: begin
				r.res_num = 0;
				r.res_den = 0;
				return r;
			end
		endcase
		g = euclid_gcd(n, d);
		r.res_num = trunc_quot(n, g);
		r.res_den = trunc_quot(d, g);
		return r;
	endfunction

	assign pending = reduced_q.size();

	always @(posedge clk or negedge arst_n) begin
		rar_pkg::out_t want;
		if (!arst_n) begin
			fail_count <= 0;
			checked <= 0;
		end else begin
			if (start && !busy) begin
				reduced_q = {reduced_q, reduce_rational(item)};
			end
			if (strobe) begin
				checked <= checked + 1;
				if (reduced_q.size() == 0) begin
					$display("%0t: unexpected result %0d/%0d", $time,
						result.res_num, result.res_den);
					fail_count <= fail_count + 1;
				end else begin
					want = reduced_q.pop_front();
					if (result.res_num !== want.res_num) begin
						$display("%0t: res_num expected %0d actual %0d", $time,
							want.res_num, result.res_num);
						fail_count <= fail_count + 1;
					end else if (result.res_den !== want.res_den) begin
						$display("%0t: res_den expected %0d actual %0d", $time,
							want.res_den, result.res_den);
						fail_count <= fail_count + 1;
					end
				end
			end
		end
	end
endmodule

@@ tb/tb_rational_arith_reduce.sv @@
module tb_rational_arith_reduce;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int LIMIT = 20_000_000;
	localparam int RANDOM_ITEMS = 550;
	localparam logic signed [31:0] MOST_NEG = 32'sh8000_0000;
	localparam logic signed [31:0] MOST_POS = 32'sh7fff_ffff;

	logic          clk = 1'b0;
	logic          arst_n = 1'b0;
	logic          start = 1'b0;
	rar_pkg::in_t  item = '0;
	logic          busy, strobe;
	rar_pkg::out_t result;
	int            fail_count, pending, checked;
	int            cycles = 0;
	int            idle_pct = 0;
	int            sent = 0;

	rational_arith_reduce u_dut (
		.clk(clk), .arst_n(arst_n), .start(start), .item(item),
		.busy(busy), .strobe(strobe), .result(result)
	);

	rational_arith_reduce_check u_check (
		.clk(clk), .arst_n(arst_n), .start(start), .busy(busy), .item(item),
		.strobe(strobe), .result(result), .fail_count(fail_count),
		.pending(pending), .checked(checked)
	);

	always begin
		#1 clk = 1'b1;
		#1 clk = 1'b0;
	end

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > LIMIT) begin
			$display("tb: failure");
			$finish;
		end
	end

	// Mostly small operands keep Euclid short; full-width ones are rarer.
	function automatic logic signed [31:0] rand_operand();
		int pick;
		pick = $urandom_range(99);
		if (pick < 45) begin
			return $signed($urandom_range(40)) - 20;
		end else if (pick < 75) begin
			return $signed($urandom_range(131072)) - 65536;
		end else if (pick < 92) begin
			return $urandom;
		end
		case ($urandom_range(4))
			0: return 0;
			1: return 1;
			2: return -1;
			3: return MOST_NEG;
			default: return MOST_POS;
		endcase
	endfunction

	task automatic send_op(logic [2:0] cmd, logic signed [31:0] an, logic signed [31:0] ad,
			logic signed [31:0] bn, logic signed [31:0] bd);
		start <= 1'b1;
		item <= '{cmd: cmd, a_num: an, a_den: ad, b_num: bn, b_den: bd};
		@(posedge clk);
		while (busy) begin
			@(posedge clk);
		end
		sent++;
		if ($urandom_range(99) < idle_pct) begin
			start <= 1'b0;
			@(posedge clk);
			while ($urandom_range(99) < idle_pct) begin
				@(posedge clk);
			end
		end
	endtask

	task automatic drain();
		start <= 1'b0;
		@(posedge clk);
		while (pending != 0) begin
			@(posedge clk);
		end
	endtask

	initial begin
		logic [2:0] cmd;
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Every operation, zero denominators, wrapping extremes and unused codes.
		send_op(rar_pkg::CMD_ADD, 1, 2, 1, 3);
		send_op(rar_pkg::CMD_SUB, 1, 2, 1, 2);
		send_op(rar_pkg::CMD_MUL, -3, 4, 8, -9);
		send_op(rar_pkg::CMD_DIV, 2, 3, 4, 5);
		send_op(rar_pkg::CMD_GCD, 6, 4, 9, 2);
		send_op(rar_pkg::CMD_DIV, 5, 7, 0, 3);
		send_op(rar_pkg::CMD_ADD, 0, 0, 0, 0);
		send_op(rar_pkg::CMD_MUL, 7, 0, 3, 5);
		send_op(rar_pkg::CMD_GCD, 0, 0, 0, 0);
		send_op(rar_pkg::CMD_MUL, MOST_NEG, 1, MOST_NEG, 1);
		send_op(rar_pkg::CMD_MUL, MOST_NEG, -1, MOST_NEG, 1);
		send_op(rar_pkg::CMD_ADD, MOST_NEG, MOST_NEG, MOST_NEG, MOST_NEG);
		send_op(rar_pkg::CMD_SUB, MOST_POS, MOST_NEG, MOST_NEG, MOST_POS);
		send_op(rar_pkg::CMD_DIV, MOST_POS, MOST_POS, MOST_NEG, -1);
		send_op(rar_pkg::CMD_GCD, MOST_NEG, -1, MOST_POS, MOST_NEG);
		send_op(rar_pkg::CMD_MUL, -1, -1, -1, -1);
		send_op(3'd5, 1, 2, 3, 4);
		send_op(3'd6, -1, -1, -1, -1);
		send_op(3'd7, MOST_NEG, MOST_POS, 0, 1);
		send_op(rar_pkg::CMD_ADD, -5, 10, -5, 10);
		drain();

		for (int phase = 0; phase < 3; phase++) begin
			idle_pct = (phase == 0) ? 0 : (phase == 1) ? 82 : 8;
			for (int i = 0; i < RANDOM_ITEMS / 3; i++) begin
				cmd = ($urandom_range(19) == 0) ? 3'($urandom_range(7, 5))
					: 3'($urandom_range(4));
				send_op(cmd, rand_operand(), rand_operand(), rand_operand(),
					rand_operand());
			end
			// Let the pipeline empty before the next phase.
			drain();
		end

		repeat (200) @(posedge clk);
		$display("tb: %0d transfers sent, %0d results checked, all operations,", sent, checked);
		$display("tb: zero and extreme operands, unused codes, three idling phases");
		if (fail_count == 0) begin
			$display("tb: success");
		end else begin
			$display("tb: failure");
		end
		$finish;
	end
endmodule
